FILE: sv/tsc_pkg.sv
package tsc_pkg;

  localparam int unsigned DigitW   = 4;
  localparam int unsigned MplierW  = 16;
  localparam int unsigned McandW   = 32;
  localparam int unsigned ProdW    = McandW + MplierW;
  localparam int unsigned MulSteps = MplierW / DigitW;
  localparam int unsigned StepW    = $clog2(MulSteps + 1);
  localparam int unsigned CfgIdxW  = 8;
  localparam int unsigned CfgDataW = 32;

  localparam logic [CfgIdxW-1:0] CFG_SLIDE_DIST = 8'd0;
  localparam logic [CfgIdxW-1:0] CFG_ANGLE      = 8'd1;

  localparam logic [31:0] SLIDE_DIST_RST = 32'd100;
  localparam logic [3:0]  ANGLE_RST      = 4'd3;

  localparam logic [7:0] CODE_IDLE     = 8'h00;
  localparam logic [7:0] CODE_FIRST    = 8'h01;
  localparam logic [7:0] CODE_IDLE_ALT = 8'h02;
  localparam logic [7:0] CODE_PRESSING = 8'h03;

  typedef enum logic [1:0] {
    PH_IDLE     = 2'd0,
    PH_FIRST    = 2'd1,
    PH_PRESSING = 2'd2,
    PH_RELEASED = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    ACT_UNTOUCHED  = 3'd0,
    ACT_NOSLIDE    = 3'd1,
    ACT_VERTICAL   = 3'd2,
    ACT_HORIZONTAL = 3'd3,
    ACT_CLICK      = 3'd4,
    ACT_VFLICK     = 3'd5,
    ACT_HFLICK     = 3'd6
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPD,
    ST_MX,
    ST_WX,
    ST_WY,
    ST_WA,
    ST_DEC
  } state_e;

  typedef struct packed {
    logic                start;
    logic [McandW-1:0]   mcand;
    logic [MplierW-1:0]  mplier;
    logic [StepW-1:0]    steps;
  } mul_req_t;

  typedef struct packed {
    logic               done;
    logic [ProdW-1:0]   product;
  } mul_rsp_t;

endpackage

FILE: sv/tsc_if.sv
interface tsc_in_if;
  logic               valid;
  logic               ready;
  logic               report_new;
  logic [7:0]         report_code;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [15:0]        shown_page;
  logic [15:0]        caller_page;

  modport source (output valid, report_new, report_code, pos_x, pos_y, shown_page,
                  caller_page, input ready);
  modport sink   (input valid, report_new, report_code, pos_x, pos_y, shown_page,
                  caller_page, output ready);
endinterface

interface tsc_out_if;
  logic               valid;
  logic               ready;
  logic [2:0]         action;
  logic signed [15:0] speed_x;
  logic signed [15:0] speed_y;
  logic [1:0]         touch_phase;

  modport source (output valid, action, speed_x, speed_y, touch_phase, input ready);
  modport sink   (input valid, action, speed_x, speed_y, touch_phase, output ready);
endinterface

interface tsc_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/touch_swipe_classifier_unit.sv
// Channel  | Dir | Handshake    | Payload
// item_i   | in  | valid/ready  | report_new, report_code, pos_x, pos_y, shown_page, caller_page
// result_o | out | valid/ready  | action, speed_x, speed_y, touch_phase
// cfg_i    | in  | valid/ready  | index, data (0 slide_distance_sq, 1 angle_factor)
//
// From acceptance to its result register an item goes through one state update,
// then dx*dx and dy*dy at four 4-bit digits each and y2*angle_factor in one digit, all
// on one shared digit-serial multiplier, then the decision; the next item is taken after
// the return to idle. Reset clears phase, slide mode, positions, speeds and both registers
// to their reset values. A result waiting on a stalled result_o does not block the next item;
// the next result waits in the decision state until the register is free.
module touch_swipe_classifier_unit
  import tsc_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  tsc_in_if.sink     item_i,
  tsc_out_if.source  result_o,
  tsc_cfg_if.sink    cfg_i
);

  state_e state_q, state_d;

  logic [31:0] slide_dist_q;
  logic [3:0]  angle_q;

  logic        new_q;
  logic [7:0]  code_q;
  logic [15:0] in_x_q, in_y_q, shown_q, caller_q;

  phase_e      phase_q, phase_d;
  action_e     slide_q, slide_d;
  logic [15:0] press_page_q, press_page_d;
  logic [15:0] press_x_q, press_x_d, press_y_q, press_y_d;
  logic [15:0] last_x_q, last_x_d, last_y_q, last_y_d;
  logic [15:0] cur_x_q, cur_x_d, cur_y_q, cur_y_d;
  logic [15:0] spd_x_q, spd_x_d, spd_y_q, spd_y_d;

  logic [31:0] x2_q, x2_d, y2_q, y2_d;
  logic [35:0] wy_q, wy_d;

  logic        out_valid_q, out_valid_d;
  action_e     out_act_q, out_act_d;
  logic [15:0] out_spx_q, out_spx_d, out_spy_q, out_spy_d;
  logic [1:0]  out_ph_q, out_ph_d;

  mul_req_t    mul_req;
  mul_rsp_t    mul_rsp;

  logic [15:0] dx, dy, mag_x, mag_y;
  logic        reached, dir_vert, in_fire;
  action_e     dir, mode;

  tsc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  assign item_i.ready = (state_q == ST_IDLE);
  assign in_fire      = item_i.valid && item_i.ready;
  assign cfg_i.ready  = 1'b1;

  assign dx    = press_x_q - cur_x_q;
  assign dy    = press_y_q - cur_y_q;
  assign mag_x = dx[15] ? 16'(-dx) : dx;
  assign mag_y = dy[15] ? 16'(-dy) : dy;

  assign reached  = (y2_q >= slide_dist_q) || (x2_q >= slide_dist_q);
  assign dir_vert = (wy_q >= {4'b0, x2_q});
  assign dir      = dir_vert ? ACT_VERTICAL : ACT_HORIZONTAL;

  always_comb begin
    state_d      = state_q;
    phase_d      = phase_q;
    slide_d      = slide_q;
    press_page_d = press_page_q;
    press_x_d    = press_x_q;
    press_y_d    = press_y_q;
    last_x_d     = last_x_q;
    last_y_d     = last_y_q;
    cur_x_d      = cur_x_q;
    cur_y_d      = cur_y_q;
    spd_x_d      = spd_x_q;
    spd_y_d      = spd_y_q;
    x2_d         = x2_q;
    y2_d         = y2_q;
    wy_d         = wy_q;
    out_valid_d  = out_valid_q && !result_o.ready;
    out_act_d    = out_act_q;
    out_spx_d    = out_spx_q;
    out_spy_d    = out_spy_q;
    out_ph_d     = out_ph_q;
    mul_req      = '0;
    mode         = slide_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_UPD;
        end
      end
      ST_UPD: begin
        if (new_q) begin
          if (code_q == CODE_FIRST) begin
            press_x_d = in_x_q;
            press_y_d = in_y_q;
            last_x_d  = in_x_q;
            last_y_d  = in_y_q;
            phase_d   = PH_FIRST;
          end else if (code_q == CODE_PRESSING) begin
            last_x_d = cur_x_q;
            last_y_d = cur_y_q;
            phase_d  = PH_PRESSING;
          end else begin
            phase_d = PH_RELEASED;
          end
          cur_x_d = in_x_q;
          cur_y_d = in_y_q;
        end else if (code_q == CODE_IDLE || code_q == CODE_IDLE_ALT) begin
          phase_d = PH_IDLE;
        end
        state_d = ST_MX;
      end
      ST_MX: begin
        mul_req.start  = 1'b1;
        mul_req.mcand  = McandW'(mag_x);
        mul_req.mplier = mag_x;
        mul_req.steps  = StepW'(MulSteps);
        state_d        = ST_WX;
      end
      ST_WX: begin
        if (mul_rsp.done) begin
          x2_d           = mul_rsp.product[31:0];
          mul_req.start  = 1'b1;
          mul_req.mcand  = McandW'(mag_y);
          mul_req.mplier = mag_y;
          mul_req.steps  = StepW'(MulSteps);
          state_d        = ST_WY;
        end
      end
      ST_WY: begin
        if (mul_rsp.done) begin
          y2_d           = mul_rsp.product[31:0];
          mul_req.start  = 1'b1;
          mul_req.mcand  = mul_rsp.product[31:0];
          mul_req.mplier = {angle_q, {(MplierW-DigitW){1'b0}}};
          mul_req.steps  = StepW'(1);
          state_d        = ST_WA;
        end
      end
      ST_WA: begin
        if (mul_rsp.done) begin
          wy_d    = mul_rsp.product[35:0];
          state_d = ST_DEC;
        end
      end
      ST_DEC: begin
        if (!out_valid_q || result_o.ready) begin
          out_act_d = ACT_NOSLIDE;
          if (phase_q == PH_IDLE) begin
            slide_d   = ACT_UNTOUCHED;
            out_act_d = ACT_UNTOUCHED;
          end else if (phase_q == PH_FIRST) begin
            press_page_d = shown_q;
            slide_d      = ACT_NOSLIDE;
          end else if (caller_q != press_page_q) begin
            out_act_d = ACT_NOSLIDE;
          end else if (phase_q == PH_PRESSING) begin
            if (slide_q == ACT_NOSLIDE && reached) begin
              mode = dir;
            end
            slide_d   = mode;
            out_act_d = mode;
          end else if (slide_q == ACT_NOSLIDE && !reached) begin
            out_act_d = ACT_CLICK;
          end else begin
            if (slide_q == ACT_NOSLIDE) begin
              mode = dir;
            end
            slide_d = mode;
            if (mode == ACT_VERTICAL) begin
              spd_y_d   = last_y_q - cur_y_q;
              out_act_d = ACT_VFLICK;
            end else begin
              spd_x_d   = last_x_q - cur_x_q;
              out_act_d = ACT_HFLICK;
            end
          end
          out_spx_d   = spd_x_d;
          out_spy_d   = spd_y_d;
          out_ph_d    = phase_q;
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      out_valid_q  <= 1'b0;
      slide_dist_q <= SLIDE_DIST_RST;
      angle_q      <= ANGLE_RST;
      phase_q      <= PH_IDLE;
      slide_q      <= ACT_UNTOUCHED;
      press_page_q <= '0;
      press_x_q    <= '0;
      press_y_q    <= '0;
      last_x_q     <= '0;
      last_y_q     <= '0;
      cur_x_q      <= '0;
      cur_y_q      <= '0;
      spd_x_q      <= '0;
      spd_y_q      <= '0;
    end else begin
      state_q      <= state_d;
      out_valid_q  <= out_valid_d;
      phase_q      <= phase_d;
      slide_q      <= slide_d;
      press_page_q <= press_page_d;
      press_x_q    <= press_x_d;
      press_y_q    <= press_y_d;
      last_x_q     <= last_x_d;
      last_y_q     <= last_y_d;
      cur_x_q      <= cur_x_d;
      cur_y_q      <= cur_y_d;
      spd_x_q      <= spd_x_d;
      spd_y_q      <= spd_y_d;
      if (cfg_i.valid && cfg_i.ready) begin
        unique case (cfg_i.index)
          CFG_SLIDE_DIST: slide_dist_q <= cfg_i.data;
          CFG_ANGLE:      angle_q      <= cfg_i.data[3:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      new_q    <= item_i.report_new;
      code_q   <= item_i.report_code;
      in_x_q   <= item_i.pos_x;
      in_y_q   <= item_i.pos_y;
      shown_q  <= item_i.shown_page;
      caller_q <= item_i.caller_page;
    end
    x2_q      <= x2_d;
    y2_q      <= y2_d;
    wy_q      <= wy_d;
    out_act_q <= out_act_d;
    out_spx_q <= out_spx_d;
    out_spy_q <= out_spy_d;
    out_ph_q  <= out_ph_d;
  end

  assign result_o.valid       = out_valid_q;
  assign result_o.action      = out_act_q;
  assign result_o.speed_x     = out_spx_q;
  assign result_o.speed_y     = out_spy_q;
  assign result_o.touch_phase = out_ph_q;

endmodule

FILE: sv/tsc_mul.sv
module tsc_mul
  import tsc_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  mul_req_t req_i,
  output mul_rsp_t rsp_o
);

  logic [ProdW-1:0]   acc_q, acc_d;
  logic [McandW-1:0]  mcand_q, mcand_d;
  logic [MplierW-1:0] mplier_q, mplier_d;
  logic [StepW-1:0]   cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [McandW+DigitW-1:0] partial;

  assign partial = mcand_q * mplier_q[MplierW-1 -: DigitW];

  always_comb begin
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (req_i.start) begin
      acc_d    = '0;
      mcand_d  = req_i.mcand;
      mplier_d = req_i.mplier;
      cnt_d    = req_i.steps;
      busy_d   = 1'b1;
    end else if (busy_q) begin
      // take one digit, most significant first
      acc_d    = (acc_q << DigitW) + ProdW'(partial);
      mplier_d = mplier_q << DigitW;
      cnt_d    = cnt_q - StepW'(1);
      if (cnt_q == StepW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mcand_q  <= mcand_d;
    mplier_q <= mplier_d;
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule
